// ===== sv/wsd_pkg.sv =====
// wsd_pkg: shared types and constants of the task deque core
// request and result payload structs, operation and status codes, derived widths
// no dependencies
package wsd_pkg;

    // fixed capacity of the deque, in tasks
    localparam int CAPACITY = 1024;

    // derived widths
    localparam int TASK_W = 32;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W  = $clog2(2 * CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);

    // operation codes
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_TAKE  = 2'd1,
        OP_STEAL = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // one request
    typedef struct packed {
        op_t                       operation;
        logic signed [TASK_W-1:0]  task_word;
    } req_t;

    // one result
    typedef struct packed {
        logic signed [TASK_W-1:0]  task_out;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

endpackage

// ===== sv/work_stealing_deque_core.sv =====
// work_stealing_deque_core: bounded task deque in a ring memory
// head and tail pointer registers, one synchronous task memory, result register
// depends on wsd_pkg
//
// usage
//   req channel (req_valid/req_ready, req): put appends req.task_word at the
//   tail, take removes the newest task, steal removes the oldest task, code 3
//   does nothing. every request gives exactly one result on the rsp channel
//   (rsp_valid/rsp_ready, rsp) with the removed task (zero otherwise), a
//   status (ok, empty, full) and the occupancy after the request.
// result timing and throughput
//   a request accepted at one edge has its result valid after that edge,
//   from the registered read of the task memory. one request per cycle is
//   taken while results are drained every cycle: the next request is
//   accepted at the edge where the pending result is taken.
// reset
//   rst_n clears head, tail and the result valid flag; the deque is empty.
//   the task memory needs no clearing since only written entries are read.
// stall
//   while a result is pending and rsp_ready is low the result holds and req_ready stays low.
module work_stealing_deque_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  wsd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wsd_pkg::rsp_t rsp
);

    localparam int CAP    = wsd_pkg::CAPACITY;
    localparam int ADDR_W = wsd_pkg::ADDR_W;
    localparam int PTR_W  = wsd_pkg::PTR_W;
    localparam int OCC_W  = wsd_pkg::OCC_W;
    localparam int TASK_W = wsd_pkg::TASK_W;
    localparam int SPAN   = 2 * CAP;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SPAN - 1);
    localparam logic [PTR_W-1:0] PTR_CAP  = PTR_W'(CAP);
    localparam logic [PTR_W:0]   SPAN_X   = (PTR_W + 1)'(SPAN);
    localparam logic [PTR_W:0]   CAP_X    = (PTR_W + 1)'(CAP);

    // pointer helpers, wrap modulo twice the capacity
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] retreat(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= PTR_CAP) ? p - PTR_CAP : p;
        return s[ADDR_W-1:0];
    endfunction

    // state
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    rd_sel_reg, rd_sel_next;
    wsd_pkg::status_t        status_reg, status_next;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic signed [TASK_W-1:0] rdata_reg;
    logic signed [TASK_W-1:0] task_mem [CAP];

    // memory port controls
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_addr;

    logic                    req_fire;
    logic [PTR_W:0]          diff;
    logic [PTR_W:0]          held;
    logic [PTR_W:0]          held_after;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    // current occupancy from the pointers
    always_comb
    begin
        diff = {1'b0, tail_reg} - {1'b0, head_reg};
        held = diff[PTR_W] ? diff + SPAN_X : diff;
    end

    // request decode, pointer update and memory port selection
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_sel_next    = rd_sel_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        held_after     = held;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = slot_of(tail_reg);
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
            rd_sel_next    = 1'b0;
            status_next    = wsd_pkg::ST_OK;
            unique case (req.operation)
                wsd_pkg::OP_PUT:
                begin
                    if (held >= CAP_X)
                    begin
                        status_next = wsd_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = slot_of(tail_reg);
                        tail_next  = advance(tail_reg);
                        held_after = held + 1'b1;
                    end
                end
                wsd_pkg::OP_TAKE:
                begin
                    if (held == '0)
                    begin
                        status_next = wsd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        mem_addr    = slot_of(retreat(tail_reg));
                        tail_next   = retreat(tail_reg);
                        rd_sel_next = 1'b1;
                        held_after  = held - 1'b1;
                    end
                end
                wsd_pkg::OP_STEAL:
                begin
                    if (held == '0)
                    begin
                        status_next = wsd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        mem_addr    = slot_of(head_reg);
                        head_next   = advance(head_reg);
                        rd_sel_next = 1'b1;
                        held_after  = held - 1'b1;
                    end
                end
                default:
                begin
                    status_next = wsd_pkg::ST_OK;
                end
            endcase
            occ_next = held_after[OCC_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rd_sel_reg    <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_sel_reg    <= rd_sel_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    // task memory, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            task_mem[mem_addr] <= req.task_word;
        end
        if (mem_re)
        begin
            rdata_reg <= task_mem[mem_addr];
        end
    end

    // result outputs
    assign rsp_valid     = rsp_valid_reg;
    assign rsp.task_out  = rd_sel_reg ? rdata_reg : '0;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = occ_reg;

    // occupancy held by the pointers never exceeds the capacity
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held <= CAP_X)
        else $error("pointer distance exceeds capacity");

    // a put on a full deque is answered full and leaves the tail alone
    a_full_put: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.operation == wsd_pkg::OP_PUT && held == CAP_X) |=>
        (rsp.status == wsd_pkg::ST_FULL && $stable(tail_reg)))
        else $error("put on full deque not refused");

    // an empty answer reports zero tasks held and no task
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == wsd_pkg::ST_EMPTY) |->
        (rsp.occupancy == '0 && rsp.task_out == '0))
        else $error("empty result with tasks held");

    // a memory read only happens for a successful take or steal
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rd_sel_reg) |-> (rsp.status == wsd_pkg::ST_OK))
        else $error("task read on refused request");

endmodule
